FILE: rtl/g2e_pkg.sv
// Shared types, constants and arithmetic helpers for the geodetic to ECEF unit.
package g2e_pkg;

  // CORDIC depth; the arctangent table has 48 entries
  localparam int CORDIC_STAGES = 32;
  localparam int ATAN_LEN      = 48;
  localparam int CORDIC_N      = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

  // Datapath widths and stage counts
  localparam int CW = 44;   // CORDIC x/y, Q40 signed
  localparam int ZW = 34;   // CORDIC angle residual
  localparam int SQRT_STEPS = 31;
  localparam int DIV_STEPS  = 74;
  localparam int MUL_LAT    = 2;    // register stages inside g2e_mul
  localparam int SIDE_LEN   = 2*MUL_LAT + 1 + SQRT_STEPS + DIV_STEPS;
  localparam int TOT_STAGES = CORDIC_N + 4*MUL_LAT + 3 + SQRT_STEPS + DIV_STEPS;

  localparam logic signed [CW-1:0] GAIN_Q40 = 44'sd667681663043;
  localparam logic [45:0] N_MAX = 46'h3FFF_FFFF_FFFF;
  localparam logic [43:0] SMA_RESET = 44'd14791517183708;
  localparam logic [43:0] ECC_RESET = 44'd1884300451817;

  // Round-half-up terms for Q40 and Q48 shifts
  localparam logic [103:0] RND_Q40 = 104'(1) << 39;
  localparam logic [103:0] RND_Q48 = 104'(1) << 47;

  // Configuration register indexes
  typedef enum logic [7:0] {
    REG_SEMI_MAJOR = 8'd0,
    REG_ECC_SQ     = 8'd1
  } reg_idx_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic [60:0] v;
    logic [61:0] res;
  } sqrt_t;

  typedef struct packed {
    logic [30:0] r;
    logic [30:0] rem;
    logic [47:0] q;
    logic        big;
  } div_t;

  // Trig values carried alongside the radius computation
  typedef struct packed {
    logic signed [CW-1:0] cl;
    logic signed [CW-1:0] sl;
    logic signed [CW-1:0] cn;
    logic signed [CW-1:0] sn;
  } side_t;

  // Trig magnitudes and output signs for the final products
  typedef struct packed {
    logic [CW-1:0] cn;
    logic [CW-1:0] sn;
    logic [CW-1:0] sl;
    logic          neg_x;
    logic          neg_y;
    logic          neg_z;
  } mag_t;

  // atan(2^-i) in binary-angle units, 2^32 per turn
  function automatic logic [29:0] atan_val(input int i);
    logic [29:0] t;
    case (i)
      0:  t = 30'h20000000;
      1:  t = 30'h12E4051E;
      2:  t = 30'h09FB385B;
      3:  t = 30'h051111D4;
      4:  t = 30'h028B0D43;
      5:  t = 30'h0145D7E1;
      6:  t = 30'h00A2F61E;
      7:  t = 30'h00517C55;
      8:  t = 30'h0028BE53;
      9:  t = 30'h00145F2F;
      10: t = 30'h000A2F98;
      11: t = 30'h000517CC;
      12: t = 30'h00028BE6;
      13: t = 30'h000145F3;
      14: t = 30'h0000A2FA;
      15: t = 30'h0000517D;
      16: t = 30'h000028BE;
      17: t = 30'h0000145F;
      18: t = 30'h00000A30;
      19: t = 30'h00000518;
      20: t = 30'h0000028C;
      21: t = 30'h00000146;
      22: t = 30'h000000A3;
      23: t = 30'h00000051;
      24: t = 30'h00000029;
      25: t = 30'h00000014;
      26: t = 30'h0000000A;
      27: t = 30'h00000005;
      28: t = 30'h00000003;
      29: t = 30'h00000001;
      30: t = 30'h00000001;
      default: t = 30'h0;
    endcase
    return t;
  endfunction

  // Apply sign to a magnitude and clamp to [-2^44, 2^44-1]
  function automatic logic [44:0] sat_mag(input logic [63:0] m, input logic neg);
    logic [44:0] o;
    if (!neg) o = (m > 64'h0FFF_FFFF_FFFF) ? 45'h0FFF_FFFF_FFFF : m[44:0];
    else o = (m > 64'h1000_0000_0000) ? 45'h1000_0000_0000 : 45'(64'd0 - m);
    return o;
  endfunction

endpackage

FILE: rtl/g2e_in_if.sv
// Request channel carrying one geodetic position.
interface g2e_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] latitude;
  logic signed [31:0] longitude;
  modport source (output valid, latitude, longitude, input ready);
  modport sink   (input valid, latitude, longitude, output ready);
endinterface

FILE: rtl/g2e_out_if.sv
// Result channel carrying one ECEF position.
interface g2e_out_if;
  logic               valid;
  logic               ready;
  logic signed [44:0] ecef_x;
  logic signed [44:0] ecef_y;
  logic signed [44:0] ecef_z;
  modport source (output valid, ecef_x, ecef_y, ecef_z, input ready);
  modport sink   (input valid, ecef_x, ecef_y, ecef_z, output ready);
endinterface

FILE: rtl/g2e_cfg_if.sv
// Configuration write channel.
interface g2e_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [43:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/g2e_cordic_cell.sv
// One rotation-mode CORDIC micro-rotation with its output register.
module g2e_cordic_cell
  import g2e_pkg::*;
(
  input  logic       clk,
  input  logic       en,
  input  logic [5:0] shift,
  input  logic [29:0] atan,
  input  cordic_t    d_in,
  output cordic_t    d_out
);

  cordic_t nxt;

  // rotate toward zero residual angle
  always_comb begin
    if (!d_in.z[ZW-1]) begin
      nxt.x = d_in.x - (d_in.y >>> shift);
      nxt.y = d_in.y + (d_in.x >>> shift);
      nxt.z = d_in.z - $signed(ZW'(atan));
    end else begin
      nxt.x = d_in.x + (d_in.y >>> shift);
      nxt.y = d_in.y - (d_in.x >>> shift);
      nxt.z = d_in.z + $signed(ZW'(atan));
    end
  end

  always_ff @(posedge clk) begin
    if (en) d_out <= nxt;
  end

endmodule

FILE: rtl/g2e_sqrt_cell.sv
// One digit of the restoring integer square root, registered.
module g2e_sqrt_cell
  import g2e_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [60:0] bitv,
  input  sqrt_t       d_in,
  output sqrt_t       d_out
);

  sqrt_t       nxt;
  logic [61:0] trial;

  always_comb begin
    trial = d_in.res + 62'(bitv);
    if ({1'b0, d_in.v} >= trial) begin
      nxt.v   = 61'({1'b0, d_in.v} - trial);
      nxt.res = (d_in.res >> 1) + 62'(bitv);
    end else begin
      nxt.v   = d_in.v;
      nxt.res = d_in.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) d_out <= nxt;
  end

endmodule

FILE: rtl/g2e_div_cell.sv
// One quotient bit of the restoring divider, registered.
module g2e_div_cell
  import g2e_pkg::*;
(
  input  logic clk,
  input  logic en,
  input  logic abit,
  input  div_t d_in,
  output div_t d_out
);

  div_t        nxt;
  logic [31:0] remsh;
  logic        qb;

  always_comb begin
    remsh = {d_in.rem, abit};
    qb    = (remsh >= {1'b0, d_in.r});
    nxt.r   = d_in.r;
    nxt.rem = qb ? 31'(remsh - {1'b0, d_in.r}) : remsh[30:0];
    nxt.big = d_in.big | d_in.q[47];
    nxt.q   = {d_in.q[46:0], qb};
  end

  always_ff @(posedge clk) begin
    if (en) d_out <= nxt;
  end

endmodule

FILE: rtl/geodetic_to_ecef_unit.sv
// Geodetic (latitude, longitude, zero height) to ECEF converter, one fully pipelined row.
//
// Takes one position request per clock and returns x, y, z in nautical miles (Q32) in order.
// The row holds, in order: CORDIC cells for both angles, a sign-unfold register, two products
// for e2 sin^2, the root input register, 31 square-root cells, 74 divider cells, a radius
// register, two rounds of products and the output register. A stalled output freezes the whole
// row; in_ch.ready is high whenever the output register is empty or being taken. Configuration
// writes are always accepted and take effect at once, also on items already in the row; write
// only while the pipeline is empty.
module geodetic_to_ecef_unit
  import g2e_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  g2e_in_if.sink  in_ch,
  g2e_out_if.source out_ch,
  g2e_cfg_if.sink cfg_ch
);

  logic        en;
  logic [43:0] sma_r;
  logic [43:0] ecc_r;
  logic [TOT_STAGES-1:0] vld_r;
  logic        out_valid_r;

  assign en           = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = en;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sma_r <= SMA_RESET;
      ecc_r <= ECC_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_SEMI_MAJOR: sma_r <= cfg_ch.data;
        REG_ECC_SQ:     ecc_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // valid row, advances with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[TOT_STAGES-2:0], in_ch.valid};
      out_valid_r <= vld_r[TOT_STAGES-1];
    end
  end

  // quadrant fold into +-90 degrees
  logic [31:0] lat_u, lon_u, lat_f, lon_f;
  logic        fl_lat, fl_lon;
  cordic_t     c_lat [0:CORDIC_N];
  cordic_t     c_lon [0:CORDIC_N];
  logic        negl_r [1:CORDIC_N];
  logic        negn_r [1:CORDIC_N];

  always_comb begin
    lat_u  = in_ch.latitude;
    lon_u  = in_ch.longitude;
    fl_lat = 32'(lat_u + 32'h4000_0000) >> 31 == 32'd1;
    fl_lon = 32'(lon_u + 32'h4000_0000) >> 31 == 32'd1;
    lat_f  = fl_lat ? (lat_u ^ 32'h8000_0000) : lat_u;
    lon_f  = fl_lon ? (lon_u ^ 32'h8000_0000) : lon_u;
    c_lat[0].x = GAIN_Q40;
    c_lat[0].y = '0;
    c_lat[0].z = $signed({{(ZW-32){lat_f[31]}}, lat_f});
    c_lon[0].x = GAIN_Q40;
    c_lon[0].y = '0;
    c_lon[0].z = $signed({{(ZW-32){lon_f[31]}}, lon_f});
  end

  // CORDIC row, both angles side by side
  for (genvar g = 0; g < CORDIC_N; g++) begin : g_cordic
    g2e_cordic_cell u_lat (
      .clk(clk), .en(en), .shift(6'(g)), .atan(atan_val(g)),
      .d_in(c_lat[g]), .d_out(c_lat[g+1])
    );
    g2e_cordic_cell u_lon (
      .clk(clk), .en(en), .shift(6'(g)), .atan(atan_val(g)),
      .d_in(c_lon[g]), .d_out(c_lon[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      negl_r[1] <= fl_lat;
      negn_r[1] <= fl_lon;
      for (int k = 1; k < CORDIC_N; k++) begin
        negl_r[k+1] <= negl_r[k];
        negn_r[k+1] <= negn_r[k];
      end
    end
  end

  // stage P1: unfold signs, clamp |sin lat|
  side_t       p1_nxt, p1_r;
  logic [40:0] sa;
  logic [40:0] sa_r;

  always_comb begin
    p1_nxt.cl = negl_r[CORDIC_N] ? -c_lat[CORDIC_N].x : c_lat[CORDIC_N].x;
    p1_nxt.sl = negl_r[CORDIC_N] ? -c_lat[CORDIC_N].y : c_lat[CORDIC_N].y;
    p1_nxt.cn = negn_r[CORDIC_N] ? -c_lon[CORDIC_N].x : c_lon[CORDIC_N].x;
    p1_nxt.sn = negn_r[CORDIC_N] ? -c_lon[CORDIC_N].y : c_lon[CORDIC_N].y;
    if (p1_nxt.sl[CW-1]) sa = (44'(-p1_nxt.sl) > 44'(1) << 40) ? 41'(1) << 40
                                                              : 41'(-p1_nxt.sl);
    else sa = (44'(p1_nxt.sl) > 44'(1) << 40) ? 41'(1) << 40 : 41'(p1_nxt.sl);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r <= p1_nxt;
      sa_r <= sa;
    end
  end

  // sin^2 of latitude, then e2 * sin^2, both rounded to Q40 / Q48
  logic [103:0] m1_p, m2_p;

  g2e_mul u_m1 (
    .clk(clk), .en(en), .a(52'(sa_r)), .b(52'(sa_r)), .rnd(RND_Q40), .p(m1_p)
  );
  g2e_mul u_m2 (
    .clk(clk), .en(en), .a(52'(ecc_r)), .b(52'(m1_p[80:40])), .rnd(RND_Q40), .p(m2_p)
  );

  // stage P2: 1 - e2*sin^2, scaled for the root
  logic [48:0] es, dd;
  logic [60:0] v_r;
  side_t       side_r [0:SIDE_LEN-1];

  always_comb begin
    es = m2_p[88:40];
    dd = (es < (49'(1) << 48)) ? (49'(1) << 48) - es : '0;
    if (dd == '0) dd = 49'd1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r       <= {dd[48:0], 12'b0};
      side_r[0] <= p1_r;
      for (int k = 0; k < SIDE_LEN - 1; k++) side_r[k+1] <= side_r[k];
    end
  end

  // square-root row
  sqrt_t sq [0:SQRT_STEPS];
  assign sq[0] = '{v: v_r, res: '0};

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    g2e_sqrt_cell u_sq (
      .clk(clk), .en(en), .bitv(61'(1) << (60 - 2*g)),
      .d_in(sq[g]), .d_out(sq[g+1])
    );
  end

  // divider row: N = a * 2^30 / r
  div_t dv [0:DIV_STEPS];
  assign dv[0] = '{r: sq[SQRT_STEPS].res[30:0], rem: '0, q: '0, big: 1'b0};

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    logic abit;
    if (DIV_STEPS - 1 - g >= 30) begin : g_abit
      assign abit = sma_r[DIV_STEPS - 1 - g - 30];
    end else begin : g_zero
      assign abit = 1'b0;
    end
    g2e_div_cell u_dv (
      .clk(clk), .en(en), .abit(abit), .d_in(dv[g]), .d_out(dv[g+1])
    );
  end

  // stage P3: saturated radius, 1 - e2, trig magnitudes and output signs
  logic [45:0] n_val;
  logic [45:0] n_r;
  logic [48:0] om_r;
  logic [43:0] clm_r;
  side_t       sd_end;
  mag_t        mag_nxt;
  mag_t        mag_r [0:2*MUL_LAT];

  always_comb begin
    sd_end        = side_r[SIDE_LEN-1];
    n_val         = (dv[DIV_STEPS].big || dv[DIV_STEPS].q > 48'(N_MAX)) ? N_MAX
                                                                      : dv[DIV_STEPS].q[45:0];
    mag_nxt.cn    = sd_end.cn[CW-1] ? 44'(-sd_end.cn) : 44'(sd_end.cn);
    mag_nxt.sn    = sd_end.sn[CW-1] ? 44'(-sd_end.sn) : 44'(sd_end.sn);
    mag_nxt.sl    = sd_end.sl[CW-1] ? 44'(-sd_end.sl) : 44'(sd_end.sl);
    mag_nxt.neg_x = sd_end.cl[CW-1] ^ sd_end.cn[CW-1];
    mag_nxt.neg_y = sd_end.cl[CW-1] ^ sd_end.sn[CW-1];
    mag_nxt.neg_z = sd_end.sl[CW-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r      <= n_val;
      om_r     <= (49'(1) << 48) - 49'(ecc_r);
      clm_r    <= sd_end.cl[CW-1] ? 44'(-sd_end.cl) : 44'(sd_end.cl);
      mag_r[0] <= mag_nxt;
      for (int k = 0; k < 2*MUL_LAT; k++) mag_r[k+1] <= mag_r[k];
    end
  end

  // N (1 - e2) in Q32 and |N cos(lat)| in Q32
  logic [103:0] m3_p, m4_p;

  g2e_mul u_m3 (
    .clk(clk), .en(en), .a(52'(n_r)), .b(52'(om_r)), .rnd(RND_Q48), .p(m3_p)
  );
  g2e_mul u_m4 (
    .clk(clk), .en(en), .a(52'(n_r)), .b(52'(clm_r)), .rnd(RND_Q40), .p(m4_p)
  );

  // final products on magnitudes
  logic [103:0] m5_p, m6_p, m7_p;

  g2e_mul u_m5 (
    .clk(clk), .en(en), .a(m4_p[91:40]), .b(52'(mag_r[MUL_LAT].cn)), .rnd(RND_Q40),
    .p(m5_p)
  );
  g2e_mul u_m6 (
    .clk(clk), .en(en), .a(m4_p[91:40]), .b(52'(mag_r[MUL_LAT].sn)), .rnd(RND_Q40),
    .p(m6_p)
  );
  g2e_mul u_m7 (
    .clk(clk), .en(en), .a(m3_p[99:48]), .b(52'(mag_r[MUL_LAT].sl)), .rnd(RND_Q40),
    .p(m7_p)
  );

  // output register: signs applied with saturation
  logic [44:0] x_r, y_r, z_r;

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= sat_mag(m5_p[103:40], mag_r[2*MUL_LAT].neg_x);
      y_r <= sat_mag(m6_p[103:40], mag_r[2*MUL_LAT].neg_y);
      z_r <= sat_mag(m7_p[103:40], mag_r[2*MUL_LAT].neg_z);
    end
  end

  assign out_ch.ecef_x = x_r;
  assign out_ch.ecef_y = y_r;
  assign out_ch.ecef_z = z_r;

endmodule

// Two-stage unsigned 52 x 52 multiplier from four 26 x 26 partial products, plus a rounding term.
module g2e_mul (
  input  logic         clk,
  input  logic         en,
  input  logic [51:0]  a,
  input  logic [51:0]  b,
  input  logic [103:0] rnd,
  output logic [103:0] p
);

  logic [51:0] ll_r, lh_r, hl_r, hh_r;

  // partial products
  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= 52'(a[25:0]) * 52'(b[25:0]);
      lh_r <= 52'(a[25:0]) * 52'(b[51:26]);
      hl_r <= 52'(a[51:26]) * 52'(b[25:0]);
      hh_r <= 52'(a[51:26]) * 52'(b[51:26]);
    end
  end

  // sum with the rounding term
  always_ff @(posedge clk) begin
    if (en) begin
      p <= 104'(ll_r) + (104'(lh_r) << 26) + (104'(hl_r) << 26) + (104'(hh_r) << 52) + rnd;
    end
  end

endmodule

FILE: sim/geodetic_to_ecef_unit_test.sv
// Self-checking testbench for geodetic_to_ecef_unit: directed and random positions vs. a predictor.
module geodetic_to_ecef_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import g2e_pkg::*;

  localparam int PIPE_LAT    = CORDIC_N + 117;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int RANDOM_REQS = 1225;

  typedef struct {
    logic [44:0] x;
    logic [44:0] y;
    logic [44:0] z;
  } ecef_pos_t;

  // Scoreboard: own ellipsoid copy, fixed-point predictor, queue of expected positions
  class ecef_scoreboard;
    logic [43:0] axis_q32;
    logic [43:0] ecc_sq_q48;
    ecef_pos_t   pending_positions[$];
    int          mismatches;
    int          matched;
    longint      atan_steps[48];

    function new();
      longint tab[31] = '{
        'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
        'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
        'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
        'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
        'h00000029, 'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001,
        'h00000001};
      for (int i = 0; i < 48; i++) atan_steps[i] = (i < 31) ? tab[i] : 0;
      axis_q32   = SMA_RESET;
      ecc_sq_q48 = ECC_RESET;
      mismatches = 0;
      matched    = 0;
    endfunction

    function void set_register(reg_idx_t idx, logic [43:0] value);
      if (idx == REG_SEMI_MAJOR) axis_q32 = value;
      else if (idx == REG_ECC_SQ) ecc_sq_q48 = value;
    endfunction

    // (a*b) >> s, rounded half up, on magnitudes
    function longint unsigned mul_round(longint unsigned a, longint unsigned b, int s);
      logic [127:0] p;
      p = 128'(a) * 128'(b) + (128'd1 << (s - 1));
      p = p >> s;
      return p[63:0];
    endfunction

    function longint mul_round_signed(longint a, longint b, int s);
      longint unsigned m;
      m = mul_round((a < 0) ? -a : a, (b < 0) ? -b : b, s);
      return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    // Rotation CORDIC with quadrant fold; cos/sin in Q40
    function void rotate_angle(logic [31:0] ang, output longint c, output longint s);
      logic [31:0] probe;
      logic        flip;
      longint      x, y, z, t;
      probe = ang + 32'h40000000;
      flip  = probe[31];
      if (flip) ang = ang ^ 32'h80000000;
      z = longint'($signed(ang));
      x = longint'(GAIN_Q40);
      y = 0;
      for (int i = 0; i < CORDIC_N; i++) begin
        if (z >= 0) begin
          t = x - (y >>> i);
          y = y + (x >>> i);
          z = z - atan_steps[i];
        end else begin
          t = x + (y >>> i);
          y = y - (x >>> i);
          z = z + atan_steps[i];
        end
        x = t;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 60;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function logic [44:0] clamp45(longint v);
      if (v > 64'sd17592186044415) v = 64'sd17592186044415;
      if (v < -64'sd17592186044416) v = -64'sd17592186044416;
      return v[44:0];
    endfunction

    function ecef_pos_t predict_position(logic [31:0] lat, logic [31:0] lon);
      longint          cl, sl, cn, sn, ncl, nz;
      longint unsigned sa, s2, es, d, r, n;
      logic [127:0]    quot;
      ecef_pos_t       p;
      rotate_angle(lat, cl, sl);
      rotate_angle(lon, cn, sn);
      sa = (sl < 0) ? -sl : sl;
      if (sa > (64'd1 << 40)) sa = 64'd1 << 40;
      s2 = mul_round(sa, sa, 40);
      es = mul_round(64'(ecc_sq_q48), s2, 40);
      d  = (es < (64'd1 << 48)) ? (64'd1 << 48) - es : 0;
      // degenerate ellipsoid keeps the root positive
      if (d == 0) d = 1;
      r = int_sqrt(d << 12);
      quot = (128'(axis_q32) << 30) / 128'(r);
      n = (quot > 128'(N_MAX)) ? 64'(N_MAX) : quot[63:0];
      ncl = mul_round_signed(longint'(n), cl, 40);
      nz  = longint'(mul_round(n, (64'd1 << 48) - 64'(ecc_sq_q48), 48));
      p.x = clamp45(mul_round_signed(ncl, cn, 40));
      p.y = clamp45(mul_round_signed(ncl, sn, 40));
      p.z = clamp45(mul_round_signed(nz, sl, 40));
      return p;
    endfunction

    function void note_request(logic [31:0] lat, logic [31:0] lon);
      pending_positions.push_back(predict_position(lat, lon));
    endfunction

    function void check_result(logic [44:0] x, logic [44:0] y, logic [44:0] z);
      ecef_pos_t e;
      if (pending_positions.size() == 0) begin
        $error("result with no request outstanding: x=%h y=%h z=%h", x, y, z);
        mismatches++;
        return;
      end
      e = pending_positions.pop_front();
      if (x !== e.x) begin
        $error("ecef_x mismatch: expected %h actual %h", e.x, x);
        mismatches++;
      end
      if (y !== e.y) begin
        $error("ecef_y mismatch: expected %h actual %h", e.y, y);
        mismatches++;
      end
      if (z !== e.z) begin
        $error("ecef_z mismatch: expected %h actual %h", e.z, z);
        mismatches++;
      end
      matched++;
    endfunction
  endclass

  logic clk;
  logic rst_n;
  g2e_in_if  in_bus();
  g2e_out_if out_bus();
  g2e_cfg_if cfg_bus();

  geodetic_to_ecef_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  ecef_scoreboard board;
  longint         cycles = 0;
  bit             steady_flow;   // no gaps on either side
  bit             hold_off_req;
  int             sent;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("geodetic_to_ecef_unit verification failed");
      $finish;
    end
  end

  function automatic int gap_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady_flow || roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result side: check accepted results, stall at random or on a hold-off request
  initial begin
    int stall;
    stall = 0;
    out_bus.ready <= 1'b0;
    @(posedge clk);
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready)
        board.check_result(out_bus.ecef_x, out_bus.ecef_y, out_bus.ecef_z);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall = 400;
      end else if (stall == 0) begin
        stall = gap_length();
      end
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        stall--;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Offer one position; valid stays high across back-to-back requests
  task automatic send_position(logic [31:0] lat, logic [31:0] lon);
    int g;
    g = gap_length();
    if (g > 0) begin
      in_bus.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.latitude  <= lat;
    in_bus.longitude <= lon;
    do @(posedge clk); while (!in_bus.ready);
    board.note_request(lat, lon);
    sent++;
  endtask

  // Wait until every expected position is back, then let the row empty
  task automatic drain_pipeline();
    in_bus.valid <= 1'b0;
    while (board.pending_positions.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 20) @(posedge clk);
  endtask

  task automatic write_register(reg_idx_t idx, logic [43:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    board.set_register(idx, value);
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_latitude();
    // mostly within +-90 degrees, sometimes any bit pattern
    if ($urandom_range(0, 9) == 0) return $urandom;
    return 32'($urandom_range(0, 32'h80000000)) - 32'h40000000;
  endfunction

  task automatic random_burst(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 50) steady_flow = ~steady_flow;
      send_position(rand_latitude(), $urandom);
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    logic [31:0] lat_pts[8];
    logic [31:0] lon_pts[6];
    board        = new();
    sent         = 0;
    steady_flow  = 1'b0;
    hold_off_req = 1'b0;
    rst_n             <= 1'b0;
    in_bus.valid      <= 1'b0;
    in_bus.latitude   <= '0;
    in_bus.longitude  <= '0;
    cfg_bus.valid     <= 1'b0;
    cfg_bus.index     <= REG_SEMI_MAJOR;
    cfg_bus.data      <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: poles, equator, fold boundaries, out-of-range latitudes
    lat_pts = '{32'h00000000, 32'h40000000, 32'hC0000000, 32'h3FFFFFFF,
                32'h7FFFFFFF, 32'h80000000, 32'h20000000, 32'hFFFFFFFF};
    lon_pts = '{32'h00000000, 32'h80000000, 32'h7FFFFFFF, 32'h40000000,
                32'hC0000000, 32'hBFFFFFFF};
    for (int i = 0; i < 8; i++) send_position(lat_pts[i], lon_pts[i % 6]);
    for (int i = 0; i < 6; i++) send_position(32'h15555555, lon_pts[i]);

    // Sender pauses until all results are back
    drain_pipeline();

    // Receiver holds off while requests keep coming
    hold_off_req = 1'b1;
    steady_flow  = 1'b1;
    for (int i = 0; i < 200; i++) send_position(rand_latitude(), $urandom);
    steady_flow  = 1'b0;
    random_burst(RANDOM_REQS / 5 - 200);
    drain_pipeline();

    // Largest radius, sphere: saturating outputs
    write_register(REG_SEMI_MAJOR, 44'hFFF_FFFF_FFFF);
    write_register(REG_ECC_SQ, 44'h0);
    send_position(32'h00000000, 32'h00000000);
    send_position(32'h40000000, 32'h00000000);
    send_position(32'hC0000000, 32'h80000000);
    random_burst(RANDOM_REQS / 5);
    drain_pipeline();

    // Zero radius, largest eccentricity, then the poles with another radius
    write_register(REG_SEMI_MAJOR, 44'h0);
    write_register(REG_ECC_SQ, 44'hFFF_FFFF_FFFF);
    send_position(32'h40000000, 32'h12345678);
    random_burst(RANDOM_REQS / 10);
    drain_pipeline();
    write_register(REG_SEMI_MAJOR, 44'h123_4567_89AB);
    send_position(32'h40000000, 32'h0);
    send_position(32'hC0000000, 32'h0);
    random_burst(RANDOM_REQS / 10);
    drain_pipeline();

    // Random ellipsoid, then an ignored index, then back to defaults
    write_register(REG_SEMI_MAJOR, {$urandom, 12'($urandom)});
    write_register(REG_ECC_SQ, {$urandom, 12'($urandom)});
    random_burst(RANDOM_REQS / 5);
    drain_pipeline();
    write_register(reg_idx_t'(8'hA5), 44'h0);
    write_register(REG_SEMI_MAJOR, SMA_RESET);
    write_register(REG_ECC_SQ, ECC_RESET);
    random_burst(RANDOM_REQS / 5);

    drain_pipeline();
    $display("Sent %0d positions over five ellipsoid settings; %0d results checked, %0d mismatches",
             sent, board.matched, board.mismatches);
    if (board.mismatches == 0) begin
      $display("geodetic_to_ecef_unit verification clean");
    end else begin
      $display("geodetic_to_ecef_unit verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/g2e_pkg.sv
rtl/g2e_in_if.sv
rtl/g2e_out_if.sv
rtl/g2e_cfg_if.sv
rtl/g2e_cordic_cell.sv
rtl/g2e_sqrt_cell.sv
rtl/g2e_div_cell.sv
rtl/geodetic_to_ecef_unit.sv
sim/geodetic_to_ecef_unit_test.sv
